// File: hw/rtl/hhlp_pkg.sv
// Package for the HTTP header line parser: parser states, event and error codes,
// character constants and the result word type. No dependencies.
package hhlp_pkg;

	localparam int  FieldPosW = 13;
	localparam int  ValueMax  = 4096;
	localparam logic [12:0] ValueLimitRst = 13'd256;

	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharLf    = 8'h0A;
	localparam logic [7:0] CharColon = 8'h3A;
	localparam logic [7:0] CharSpace = 8'h20;

	typedef enum logic [9:0] {
		ST_START  = 10'b00_0000_0001,
		ST_KEY    = 10'b00_0000_0010,
		ST_COLON  = 10'b00_0000_0100,
		ST_SPACE  = 10'b00_0000_1000,
		ST_VALUE  = 10'b00_0001_0000,
		ST_CR     = 10'b00_0010_0000,
		ST_LF     = 10'b00_0100_0000,
		ST_END_CR = 10'b00_1000_0000,
		ST_DONE   = 10'b01_0000_0000,
		ST_ERROR  = 10'b10_0000_0000
	} hhlp_state_t;

	typedef enum logic [2:0] {
		EV_SKIP     = 3'd0,
		EV_KEY      = 3'd1,
		EV_COLON    = 3'd2,
		EV_SPACE    = 3'd3,
		EV_VALUE    = 3'd4,
		EV_PAIR     = 3'd5,
		EV_HDR_DONE = 3'd6,
		EV_ERROR    = 3'd7
	} hhlp_event_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_KEY_BREAK  = 3'd1,
		ERR_NO_SPACE   = 3'd2,
		ERR_NO_LF      = 3'd3,
		ERR_VALUE_LONG = 3'd4,
		ERR_END_NO_LF  = 3'd5,
		ERR_KEY_LONG   = 3'd6
	} hhlp_cause_t;

	typedef struct packed {
		hhlp_cause_t          cause;
		hhlp_event_t          ev;
		logic [FieldPosW-1:0] pos;
		logic [7:0]           data;
	} hhlp_res_t;

endpackage

// File: hw/rtl/http_header_line_parser.sv
// Top level of the HTTP header line parser: input register, parser core and
// result register with stream handshakes. Depends on hhlp_pkg and hhlp_core.
//
// Usage:
//   s_* channel carries one header byte per word; s_tuser is the restart flag,
//   which returns the parser to its start state before the byte is handled.
//   m_* channel gives exactly one result word per input word, in order.
//   cfg_we/cfg_wdata write max_value_bytes (0 acts as 1, above 4096 as 4096);
//   write only while no word is in flight.
// Path: an accepted byte passes the input register, then the result register,
//   where its result word waits until it is taken.
// Throughput: one byte per cycle while m_tready is high, set by the combinational
//   classify and count path in the core between the two registers.
// Reset: arst_n clears both stages, puts the parser in its start state and
//   sets the value limit to 256.
// Stall: while m_tready is low the result word holds; one more byte is taken
//   into the input register, after which s_tready drops until the output
//   drains.
module http_header_line_parser import hhlp_pkg::*; #(
	parameter int MAX_KEY_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] byte_out, [20:8] field_position, rest zero
	output logic [5:0]  m_tuser    // [2:0] event_res, [5:3] error_cause
);

	logic        vld_s1, vld_s2;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	hhlp_res_t   res_s2, core_res;
	logic [12:0] limit_q, cfg_clamped;
	logic        out_load, adv;

	assign out_load = !vld_s2 || m_tready;
	assign adv      = vld_s1 && out_load;
	assign s_tready = !vld_s1 || out_load;

	always_comb begin
		if (cfg_wdata == 13'd0) begin
			cfg_clamped = 13'd1;
		end else if (cfg_wdata > 13'(ValueMax)) begin
			cfg_clamped = 13'(ValueMax);
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			limit_q <= ValueLimitRst;
		end else begin
			if (cfg_we) limit_q <= cfg_clamped;
			if (s_tready) vld_s1 <= s_tvalid;
			if (out_load) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
		if (adv) res_s2 <= core_res;
	end

	hhlp_core #(
		.MAX_KEY_LEN(MAX_KEY_LEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.data_byte  (byte_s1),
		.restart    (restart_s1),
		.value_limit(limit_q),
		.res        (core_res)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {3'b000, res_s2.pos, res_s2.data};
	assign m_tuser  = {res_s2.cause, res_s2.ev};

`ifndef ASSERT_OFF
	a_cause_iff_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_s2.ev == EV_ERROR) == (res_s2.cause != ERR_NONE)))
		else $error("error cause does not match event");
	a_pos_only_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.pos != '0 |-> (res_s2.ev == EV_KEY || res_s2.ev == EV_VALUE))
		else $error("field position on a non-field event");
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !m_tready |-> !s_tready)
		else $error("input taken with both stages full and output stalled");
	a_limit_range: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q != 13'd0 && limit_q <= 13'(ValueMax))
		else $error("value limit out of range");
`endif

endmodule

// File: hw/rtl/hhlp_core.sv
// Parser core: state, key and value counters, and the byte classifier.
// Depends on hhlp_pkg.
module hhlp_core import hhlp_pkg::*; #(
	parameter int MAX_KEY_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,        // advance: word in the input register is consumed
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic [12:0] value_limit, // already clamped to 1..4096
	output hhlp_res_t   res
);

	localparam int KeyW = $clog2(MAX_KEY_LEN + 1);
	localparam logic [KeyW-1:0] KeyMax = KeyW'(MAX_KEY_LEN);

	hhlp_state_t      state_q, st_eff, st_nxt;
	logic [KeyW-1:0]  key_cnt_q, kc_eff, kc_nxt;
	logic [12:0]      val_cnt_q, vc_eff, vc_nxt;

	always_comb begin
		st_eff = restart ? ST_START : state_q;
		kc_eff = restart ? '0 : key_cnt_q;
		vc_eff = restart ? '0 : val_cnt_q;

		st_nxt    = st_eff;
		kc_nxt    = kc_eff;
		vc_nxt    = vc_eff;
		res.data  = data_byte;
		res.ev    = EV_SKIP;
		res.pos   = '0;
		res.cause = ERR_NONE;

		unique case (st_eff) inside
			ST_START, ST_LF: begin
				if (st_eff == ST_LF && data_byte == CharCr) begin
					st_nxt = ST_END_CR;
				end else if (st_eff == ST_LF && data_byte == CharLf) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_KEY_BREAK;
				end else if (data_byte == CharCr || data_byte == CharLf) begin
					// leading line breaks before the first key
					st_nxt = ST_START;
				end else begin
					st_nxt = ST_KEY;
					kc_nxt = KeyW'(1);
					vc_nxt = '0;
					res.ev = EV_KEY;
				end
			end
			ST_KEY: begin
				if (data_byte == CharColon) begin
					st_nxt = ST_COLON;
					res.ev = EV_COLON;
				end else if (data_byte == CharCr || data_byte == CharLf) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_KEY_BREAK;
				end else if (kc_eff >= KeyMax) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_KEY_LONG;
				end else begin
					kc_nxt  = kc_eff + KeyW'(1);
					res.ev  = EV_KEY;
					res.pos = FieldPosW'(kc_eff);
				end
			end
			ST_COLON: begin
				if (data_byte != CharSpace) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_NO_SPACE;
				end else begin
					st_nxt = ST_SPACE;
					res.ev = EV_SPACE;
				end
			end
			ST_SPACE: begin
				// byte after the single space is always the first value byte
				st_nxt = ST_VALUE;
				vc_nxt = 13'd1;
				res.ev = EV_VALUE;
			end
			ST_VALUE: begin
				if (data_byte == CharCr) begin
					st_nxt = ST_CR;
				end else if (vc_eff >= value_limit) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_VALUE_LONG;
				end else begin
					vc_nxt  = vc_eff + 13'd1;
					res.ev  = EV_VALUE;
					res.pos = vc_eff;
				end
			end
			ST_CR: begin
				if (data_byte != CharLf) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_NO_LF;
				end else begin
					st_nxt = ST_LF;
					kc_nxt = '0;
					vc_nxt = '0;
					res.ev = EV_PAIR;
				end
			end
			ST_END_CR: begin
				if (data_byte != CharLf) begin
					st_nxt    = ST_ERROR;
					res.ev    = EV_ERROR;
					res.cause = ERR_END_NO_LF;
				end else begin
					st_nxt = ST_DONE;
					res.ev = EV_HDR_DONE;
				end
			end
			ST_DONE: begin
				st_nxt = ST_DONE;
			end
			default: begin
				st_nxt = ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_START;
			key_cnt_q <= '0;
			val_cnt_q <= '0;
		end else if (fire) begin
			state_q   <= st_nxt;
			key_cnt_q <= kc_nxt;
			val_cnt_q <= vc_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_key_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_cnt_q <= KeyMax)
		else $error("key count beyond limit");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !restart && state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("left done state without restart");
	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !restart && state_q == ST_ERROR |-> res.ev == EV_SKIP)
		else $error("event reported while in error state");
`endif

endmodule
